// ----- design/pem_block_deframer_defines.svh -----
// Assertion macros used by the checker file of the PEM block deframer.
`ifndef PEM_BLOCK_DEFRAMER_DEFINES_SVH
`define PEM_BLOCK_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pbd_pkg.sv -----
// Types, constants and character tables of the PEM block deframer.
package pbd_pkg;

    localparam int unsigned PBD_FIFO_DEPTH = 4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0] OPEN_LEN  = 4'd10;
    localparam logic [3:0] CLOSE_LEN = 4'd8;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_BLOCK_END = 2'd1,
        KIND_DONE_OK   = 2'd2,
        KIND_DONE_ERR  = 2'd3
    } pbd_kind_t;

    typedef struct packed {
        logic       in_block;
        logic       at_line_start;
        logic [3:0] prefix_count;
        logic       prefix_failed;
        logic       header_confirmed;
        logic       pending_return;
        logic       block_seen;
    } pbd_state_t;

    localparam pbd_state_t PBD_STATE_RESET = '{
        in_block:         1'b0,
        at_line_start:    1'b1,
        prefix_count:     4'd0,
        prefix_failed:    1'b0,
        header_confirmed: 1'b0,
        pending_return:   1'b0,
        block_seen:       1'b0
    };

    // One queued command: the flushed end prefix, then up to two literal
    // bytes, then an optional block end, then an optional done word.
    typedef struct packed {
        logic [3:0] flush_n;
        logic [1:0] lit_count;
        logic [7:0] lit0;
        logic [7:0] lit1;
        logic       blk_end;
        logic       done;
        logic       done_ok;
    } pbd_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pbd_fifo_stat_t;

    function automatic logic [7:0] open_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = 8'h2D;
            4'd5:    ch = 8'h42;
            4'd6:    ch = 8'h45;
            4'd7:    ch = 8'h47;
            4'd8:    ch = 8'h49;
            4'd9:    ch = 8'h4E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] close_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0, 3'd1, 3'd2, 3'd3, 3'd4: ch = 8'h2D;
            3'd5:    ch = 8'h45;
            3'd6:    ch = 8'h4E;
            3'd7:    ch = 8'h44;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- design/pbd_if.sv -----
// Handshake channels of the PEM block deframer: text input and result output.
interface pbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface pbd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       run_end;

    modport source (output valid, output kind, output payload, output run_end, input ready);
    modport sink (input valid, input kind, input payload, input run_end, output ready);
endinterface

// ----- design/pbd_cmd_fifo.sv -----
// Short command queue between the classifying front end and the result back end.
module pbd_cmd_fifo
    import pbd_pkg::*;
#(
    parameter int unsigned DEPTH = PBD_FIFO_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pbd_cmd_t       push_cmd,
    input  logic           pop,
    output pbd_cmd_t       head,
    output pbd_fifo_stat_t stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pbd_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- design/pbd_front.sv -----
// Front end: takes text words, tracks line and header state, queues result commands.
module pbd_front
    import pbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    pbd_in_if.sink   text,
    input  logic     q_full,
    output logic     push,
    output pbd_cmd_t cmd
);

    typedef struct packed {
        pbd_state_t st;
        logic       flush;
        logic       lit;
    } pbd_feed_t;

    typedef struct packed {
        pbd_state_t st;
        logic       flush;
        logic       blk;
    } pbd_line_t;

    // One content character against the header being matched.
    function automatic pbd_feed_t feed_f(input pbd_state_t s, input logic [7:0] c);
        pbd_feed_t  r;
        logic [7:0] tag_ch;
        logic [3:0] tag_len;
        r.st    = s;
        r.flush = 1'b0;
        r.lit   = 1'b0;
        tag_ch  = s.in_block ? close_char(s.prefix_count[2:0]) : open_char(s.prefix_count);
        tag_len = s.in_block ? CLOSE_LEN : OPEN_LEN;
        if (!s.header_confirmed)
        begin
            if (s.prefix_failed)
            begin
                r.lit = s.in_block;
            end
            else if (s.prefix_count < tag_len)
            begin
                if (c == tag_ch)
                begin
                    r.st.prefix_count = s.prefix_count + 4'd1;
                end
                else
                begin
                    r.st.prefix_failed = 1'b1;
                    r.flush            = s.in_block;
                    r.lit              = s.in_block;
                end
            end
            else
            begin
                r.st.header_confirmed = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic pbd_line_t line_f(input pbd_state_t s);
        pbd_line_t r;
        r.st                = s;
        r.flush             = 1'b0;
        r.blk               = 1'b0;
        r.st.pending_return = 1'b0;
        if (s.header_confirmed)
        begin
            if (s.in_block)
            begin
                r.blk           = 1'b1;
                r.st.in_block   = 1'b0;
                r.st.block_seen = 1'b1;
            end
            else
            begin
                r.st.in_block = 1'b1;
            end
        end
        else if (s.in_block && !s.prefix_failed)
        begin
            r.flush = 1'b1;
        end
        r.st.at_line_start    = 1'b1;
        r.st.prefix_count     = 4'd0;
        r.st.prefix_failed    = 1'b0;
        r.st.header_confirmed = 1'b0;
        return r;
    endfunction

    pbd_state_t st_reg;
    pbd_state_t st_next;
    pbd_state_t s;
    pbd_feed_t  f_cr;
    pbd_feed_t  f_ch;
    pbd_line_t  le;
    logic       ws;
    logic       is_lf;
    logic       take;
    logic       lit_cr;
    logic       lit_ch;
    logic       blk;
    logic       done_ok;
    logic [3:0] flush_n;
    logic       accept;
    logic       nonempty;

    always_comb
    begin
        f_cr    = '0;
        f_ch    = '0;
        le      = '0;
        flush_n = 4'd0;
        lit_cr  = 1'b0;
        lit_ch  = 1'b0;
        blk     = 1'b0;
        ws      = (text.text_byte == CH_SPACE) ||
                  ((text.text_byte >= CH_TAB) && (text.text_byte <= CH_CR));
        is_lf   = (text.text_byte == CH_LF);
        // Leading whitespace is skipped; everything else on a line is content.
        take    = !is_lf && !(st_reg.at_line_start && ws);
        s       = st_reg;

        if (take)
        begin
            s.at_line_start = 1'b0;
            if (s.pending_return)
            begin
                s.pending_return = 1'b0;
                f_cr = feed_f(s, CH_CR);
                if (f_cr.flush)
                begin
                    flush_n = s.prefix_count;
                end
                lit_cr = f_cr.lit;
                s      = f_cr.st;
            end
            if (text.text_byte == CH_CR)
            begin
                s.pending_return = 1'b1;
            end
            else
            begin
                f_ch = feed_f(s, text.text_byte);
                if (f_ch.flush)
                begin
                    flush_n = s.prefix_count;
                end
                lit_ch = f_ch.lit;
                s      = f_ch.st;
            end
        end

        if (is_lf || text.final_byte)
        begin
            le = line_f(s);
            if (le.flush)
            begin
                flush_n = s.prefix_count;
            end
            blk = le.blk;
            s   = le.st;
        end

        done_ok = !s.in_block && s.block_seen;
        st_next = text.final_byte ? PBD_STATE_RESET : s;
    end

    assign accept     = text.valid && !q_full;
    assign text.ready = !q_full;
    assign nonempty   = (flush_n != 4'd0) || lit_cr || lit_ch || blk || text.final_byte;
    assign push       = accept && nonempty;

    assign cmd.flush_n   = flush_n;
    assign cmd.lit_count = {1'b0, lit_cr} + {1'b0, lit_ch};
    assign cmd.lit0      = lit_cr ? CH_CR : text.text_byte;
    assign cmd.lit1      = text.text_byte;
    assign cmd.blk_end   = blk;
    assign cmd.done      = text.final_byte;
    assign cmd.done_ok   = done_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= PBD_STATE_RESET;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ----- design/pbd_back.sv -----
// Back end: expands queued commands into result words, one word per cycle unless stalled.
module pbd_back
    import pbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  pbd_cmd_t   head,
    output logic       pop,
    pbd_out_if.source  result
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [3:0] lit_end;
    logic [3:0] total;
    logic       last;
    logic       load;
    pbd_kind_t  kind_sel;
    logic [7:0] payload_sel;

    logic       valid_reg;
    logic       valid_next;
    pbd_kind_t  kind_reg;
    logic [7:0] payload_reg;
    logic       run_end_reg;

    assign lit_end = head.flush_n + {2'b00, head.lit_count};
    assign total   = lit_end + {3'b000, head.blk_end} + {3'b000, head.done};
    assign last    = (idx_reg == total - 4'd1);

    always_comb
    begin
        if (idx_reg < head.flush_n)
        begin
            kind_sel    = KIND_PAYLOAD;
            payload_sel = close_char(idx_reg[2:0]);
        end
        else if (idx_reg < lit_end)
        begin
            kind_sel    = KIND_PAYLOAD;
            payload_sel = (idx_reg == head.flush_n) ? head.lit0 : head.lit1;
        end
        else if (head.blk_end && (idx_reg == lit_end))
        begin
            kind_sel    = KIND_BLOCK_END;
            payload_sel = 8'h00;
        end
        else
        begin
            kind_sel    = head.done_ok ? KIND_DONE_OK : KIND_DONE_ERR;
            payload_sel = 8'h00;
        end
    end

    // The output register is refilled whenever a command is queued and it is empty or being taken.
    assign load       = q_valid && (!valid_reg || result.ready);
    assign pop        = load && last;
    assign idx_next   = pop ? 4'd0 : idx_reg + 4'd1;
    assign valid_next = load ? 1'b1 : (result.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= kind_sel;
            payload_reg <= payload_sel;
            run_end_reg <= last;
        end
    end

    assign result.valid   = valid_reg;
    assign result.kind    = kind_reg;
    assign result.payload = payload_reg;
    assign result.run_end = run_end_reg;

endmodule

// ----- design/pem_block_deframer.sv -----
// Top level of the PEM block deframer: front end, command queue and back end.
// The block takes a PEM text one byte word per cycle on the text channel and
// gives payload bytes, block ends and a final done word on the result channel.
// A byte word is accepted in every cycle in which the command queue
// (FIFO_DEPTH entries, default four) has room; the back end drives one result
// word per cycle while the result channel takes them; one byte releases at most
// ten result words (when a seven-character end prefix fails on a held carriage
// return in the last byte of the text: the prefix, the carriage return, the
// byte itself and the done word). Bytes that release no word, such
// as leading whitespace or header characters, only pass through the front end.
// After reset the block is ready at once and needs no clearing pass; after each
// done word it starts afresh with the next text.
module pem_block_deframer
    import pbd_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = PBD_FIFO_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    pbd_in_if.sink    text,
    pbd_out_if.source result
);

    pbd_cmd_t       push_cmd;
    pbd_cmd_t       head;
    pbd_fifo_stat_t q_stat;
    logic           push;
    logic           pop;

    pbd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_stat.full),
        .push   (push),
        .cmd    (push_cmd)
    );

    pbd_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    pbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_stat.empty),
        .head    (head),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ----- design/pbd_checker.sv -----
// Port-level checks of the PEM block deframer and their binding to the top level.
`include "pem_block_deframer_defines.svh"

module pbd_checker
    import pbd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [7:0] payload,
    input logic       run_end
);

    `PBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(payload) && $stable(run_end), "result word changed while stalled")

    `PBD_ASSERT_NOW(a_no_payload, clk, rst_n, out_valid && (kind != KIND_PAYLOAD), payload == 8'h00, "payload not zero on a non-payload word")

    `PBD_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && ((kind == KIND_DONE_OK) || (kind == KIND_DONE_ERR)), run_end, "done word does not end its run")

    // A block end that does not close its run is followed at once by the done word.
    `PBD_ASSERT_NEXT(a_blk_then_done, clk, rst_n, out_valid && out_ready && (kind == KIND_BLOCK_END) && !run_end, out_valid && ((kind == KIND_DONE_OK) || (kind == KIND_DONE_ERR)), "block end not followed by done word")

endmodule

bind pem_block_deframer pbd_checker u_pbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .kind      (result.kind),
    .payload   (result.payload),
    .run_end   (result.run_end)
);

// ----- sim/pem_block_deframer_tb.sv -----
// Self-checking testbench of the PEM block deframer: random PEM texts, predicted results.
`timescale 1ns / 1ps

module pem_block_deframer_tb;
    import pbd_pkg::*;

    localparam logic [79:0] BEGIN_TAG = "-----BEGIN";
    localparam logic [63:0] END_TAG   = "-----END";
    localparam logic [39:0] WS_SET    = {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    localparam string B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
    localparam int MAX_WORDS_PER_BYTE = 11;
    localparam int RANDOM_ITEMS       = 310;

    typedef struct packed {
        pbd_kind_t  kind;
        logic [7:0] payload;
        logic       run_end;
    } result_word_t;

    // Tracks the line and block state of the text and holds the words still owed.
    class pem_frame_tracker;
        logic         in_blk;
        logic         line_start;
        logic [3:0]   tag_seen;
        logic         tag_broken;
        logic         hdr_ok;
        logic         cr_held;
        logic         blk_seen;
        result_word_t pending_words[$];
        result_word_t step_words[$];
        int           mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            in_blk     = 1'b0;
            line_start = 1'b1;
            tag_seen   = 4'd0;
            tag_broken = 1'b0;
            hdr_ok     = 1'b0;
            cr_held    = 1'b0;
            blk_seen   = 1'b0;
        endfunction

        function void push_word(pbd_kind_t kind, logic [7:0] data);
            result_word_t w;
            if (step_words.size() >= MAX_WORDS_PER_BYTE)
                return;
            w.kind    = kind;
            w.payload = (kind == KIND_PAYLOAD) ? data : 8'h00;
            w.run_end = 1'b0;
            step_words.push_back(w);
        endfunction

        // Releases the end-marker characters matched so far as payload.
        function void release_tag();
            for (int k = 0; k < int'(tag_seen) && k < int'(CLOSE_LEN); k++)
                push_word(KIND_PAYLOAD, END_TAG[8 * (7 - k) +: 8]);
        endfunction

        function void take_char(logic [7:0] c);
            int         idx;
            logic [7:0] want;
            logic [3:0] tag_len;
            idx     = int'(tag_seen);
            tag_len = in_blk ? CLOSE_LEN : OPEN_LEN;
            if (hdr_ok)
                return;
            if (tag_broken)
            begin
                if (in_blk)
                    push_word(KIND_PAYLOAD, c);
                return;
            end
            if (tag_seen < tag_len)
            begin
                want = in_blk ? END_TAG[8 * (7 - idx) +: 8] : BEGIN_TAG[8 * (9 - idx) +: 8];
                if (c == want)
                    tag_seen = tag_seen + 4'd1;
                else
                begin
                    tag_broken = 1'b1;
                    if (in_blk)
                    begin
                        release_tag();
                        push_word(KIND_PAYLOAD, c);
                    end
                end
            end
            else
                hdr_ok = 1'b1;
        endfunction

        function void close_line();
            cr_held = 1'b0;
            if (hdr_ok)
            begin
                if (in_blk)
                begin
                    push_word(KIND_BLOCK_END, 8'h00);
                    in_blk   = 1'b0;
                    blk_seen = 1'b1;
                end
                else
                    in_blk = 1'b1;
            end
            else if (in_blk && !tag_broken)
                release_tag();
            line_start = 1'b1;
            tag_seen   = 4'd0;
            tag_broken = 1'b0;
            hdr_ok     = 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            logic         ws;
            result_word_t w;
            step_words.delete();
            if (b == CH_LF)
                close_line();
            else
            begin
                ws = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
                if (!(line_start && ws))
                begin
                    line_start = 1'b0;
                    // A held carriage return is content once something else follows it.
                    if (cr_held)
                    begin
                        cr_held = 1'b0;
                        take_char(CH_CR);
                    end
                    if (b == CH_CR)
                        cr_held = 1'b1;
                    else
                        take_char(b);
                end
                if (fin)
                    close_line();
            end
            if (fin)
            begin
                push_word((!in_blk && blk_seen) ? KIND_DONE_OK : KIND_DONE_ERR, 8'h00);
                restart();
            end
            if (step_words.size() > 0)
            begin
                w = step_words.pop_back();
                w.run_end = 1'b1;
                step_words.push_back(w);
            end
            foreach (step_words[i])
                pending_words.push_back(step_words[i]);
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        task check_word(logic [1:0] kind, logic [7:0] payload, logic run_end);
            result_word_t want;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word kind %0d payload %02h", kind, payload));
                return;
            end
            want = pending_words.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (payload !== want.payload)
                report($sformatf("payload %02h, expected %02h", payload, want.payload));
            if (run_end !== want.run_end)
                report($sformatf("run_end %b, expected %b", run_end, want.run_end));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pbd_in_if  text_ch ();
    pbd_out_if result_ch ();

    pem_block_deframer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch.sink),
        .result (result_ch.source)
    );

    pem_frame_tracker tracker = new();
    logic [7:0]       text_q[$];
    int               bytes_sent;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no idling, sometimes a few cycles, now and then a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_any_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LF);
        text_q.push_back(c);
    endtask

    task automatic add_lead_ws();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n)
            text_q.push_back(WS_SET[8 * $urandom_range(0, 4) +: 8]);
    endtask

    task automatic add_eol();
        int r;
        r = $urandom_range(0, 5);
        if (r >= 3)
            text_q.push_back(CH_CR);
        if (r == 5)
            text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
    endtask

    task automatic add_header_line(string tag, int tail);
        add_lead_ws();
        add_str(tag);
        repeat (tail)
        begin
            if ($urandom_range(0, 1) == 0)
                add_any_char();
            else
                text_q.push_back(B64_SET[$urandom_range(0, B64_SET.len() - 1)]);
        end
        add_eol();
    endtask

    task automatic add_body_line();
        int         n;
        int         r;
        string      marker;
        marker = "-----END";
        add_lead_ws();
        // Partial end markers make the held prefix fail at every position.
        if ($urandom_range(0, 4) == 0)
            add_str(marker.substr(0, $urandom_range(0, 6)));
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                text_q.push_back(B64_SET[$urandom_range(0, B64_SET.len() - 1)]);
            else if (r < 70)
                text_q.push_back("-");
            else if (r < 80)
                text_q.push_back(CH_CR);
            else
                add_any_char();
        end
        add_eol();
    endtask

    task automatic build_text();
        int r;
        int blocks;
        int keep;
        text_q.delete();
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            repeat ($urandom_range(1, 10))
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            blocks = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
            repeat (blocks)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_body_line();
                add_header_line("-----BEGIN",
                                ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 3));
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(0, 7))
                        0: add_header_line("-----BEGIN", $urandom_range(0, 2));
                        1: add_header_line("-----END", 0);
                        default: add_body_line();
                    endcase
                end
                add_header_line("-----END",
                                ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 3));
            end
            if ($urandom_range(0, 3) == 0)
                add_body_line();
            if (r == 1 && text_q.size() > 1)
            begin
                keep = $urandom_range(1, text_q.size() - 1);
                while (text_q.size() > keep)
                    void'(text_q.pop_back());
            end
            else if ($urandom_range(0, 2) == 0 && text_q.size() > 1)
                void'(text_q.pop_back());
        end
        if (text_q.size() == 0)
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Offers one byte word, lowering valid only when a gap is taken.
    task automatic send_byte(input logic [7:0] b, input logic fin, input int gap);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= b;
        text_ch.final_byte <= fin;
        do
            @(posedge clk);
        while (!text_ch.ready);
        tracker.note_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_text();
        logic burst;
        burst = ($urandom_range(0, 2) == 0);
        foreach (text_q[i])
            send_byte(text_q[i], (i == text_q.size() - 1), burst ? 0 : idle_len());
    endtask

    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_words.size() != 0);
    endtask

    initial
    begin : stimulus
        int texts;
        rst_n              <= 1'b0;
        text_ch.valid      <= 1'b0;
        text_ch.text_byte  <= 8'h00;
        text_ch.final_byte <= 1'b0;
        bytes_sent = 0;
        texts      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One full block closed by the last byte, then texts that end in error.
        text_q.delete();
        text_q.push_back(CH_TAB);
        add_str("-----BEGINx");
        text_q.push_back(CH_LF);
        add_str("-----ENDy");
        send_text();
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text();
        text_q.delete();
        text_q.push_back(CH_LF);
        send_text();
        text_q.delete();
        text_q.push_back(CH_SPACE);
        text_q.push_back(8'h00);
        text_q.push_back(8'h80);
        send_text();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS)
        begin
            if (texts == 3)
                wait_drained();
            build_text();
            send_text();
            texts++;
        end

        wait_drained();
        repeat (30) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
            $display("pem_block_deframer_tb: done, clean");
        else
            $display("pem_block_deframer_tb: done, errors");
        $finish;
    end

    initial
    begin : result_sink
        int   stall_left;
        int   words;
        int   cycle;
        logic calm;
        logic held_off;
        stall_left = 0;
        words      = 0;
        cycle      = 0;
        calm       = 1'b0;
        held_off   = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 128 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (result_ch.valid && result_ch.ready)
            begin
                tracker.check_word(result_ch.kind, result_ch.payload, result_ch.run_end);
                words++;
                // One long hold-off lets the command queue fill and stall the text side.
                if (!held_off && words >= 30)
                begin
                    held_off   = 1'b1;
                    stall_left = 300;
                end
                else if (!calm)
                    stall_left = idle_len();
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        #4000000;
        $display("pem_block_deframer_tb: done, errors");
        $finish;
    end

endmodule
